/* design/assert_macros.svh */
// Assertion macros shared by the prime tester RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tdpt_pkg.sv */
// Shared types and constants of the trial-division prime tester.
// Depends on nothing; used by tdpt_divider and trial_division_prime_test_core.
package tdpt_pkg;

   // Default sizing of the core
   localparam int TABLE_DEPTH_DEF = 8192;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed widths of the beat fields and of one stored prime
   localparam int FIELD_W = 32;
   localparam int PRIME_W = 16;

   // Table limit after reset
   localparam logic [PRIME_W-1:0] LIMIT_RESET = 16'hFFFF;

   // Walk sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_FETCH,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } tdpt_state_type;

   // Status from the remainder unit
   typedef struct packed {
      logic done;
      logic rem_zero;
   } tdpt_div_stat_type;

endpackage

/* design/tdpt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module tdpt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read into a register on enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tdpt_divider.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tdpt_divider #(
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [VALUE_WIDTH-1:0]        dividend,
   input  logic [tdpt_pkg::PRIME_W-1:0]  divisor,
   output tdpt_pkg::tdpt_div_stat_type   stat
);

   localparam int STEP_W = $clog2(VALUE_WIDTH + 1);
   localparam int PW     = tdpt_pkg::PRIME_W;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [PW-1:0]          rem_ff, rem_in;
   logic [PW:0]            trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(VALUE_WIDTH);
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = dvd_ff << 1;
         step_in = step_ff - 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = PW'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[PW-1:0];
         end
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control flags under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

   `ASSERT_IMPLIES(a_done_not_busy, clock, reset, done_ff, !busy_ff, "divider done while busy")
   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff, "divider did not start")

endmodule

/* design/trial_division_prime_test_core.sv */
// Trial-division prime tester: one candidate a beat, primes kept in a RAM table.
// Depends on tdpt_pkg, tdpt_ram, tdpt_divider and assert_macros.svh.
//
// Candidates are tested one at a time against the stored primes, smallest
// first. For each stored prime tried, the core issues the table read, squares
// the prime, compares the square with the candidate and then runs the
// bit-serial remainder unit. The walk ends when the table runs out, when a
// divisor is found or when the square exceeds the candidate; the result then
// waits in the finish state until the output register is free. A result sits
// in an output register, so the next candidate is taken while it waits. A prime
// at or below table_limit that exceeds the last stored entry is appended while
// the table has room; a set first flag empties the table. Stored entries are
// never read before written. The input stalls during reset.
`include "assert_macros.svh"

module trial_division_prime_test_core #(
   parameter int TABLE_DEPTH = tdpt_pkg::TABLE_DEPTH_DEF,
   parameter int VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tdpt_pkg::FIELD_W-1:0]  req_candidate,
   input  logic                          req_first,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tdpt_pkg::FIELD_W-1:0]  rsp_tested_value,
   output logic                          rsp_is_prime,
   output logic                          rsp_undecided,
   // table limit register
   input  logic                          csr_wr_en,
   input  logic [tdpt_pkg::PRIME_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int FW    = tdpt_pkg::FIELD_W;
   localparam int PW    = tdpt_pkg::PRIME_W;

   tdpt_pkg::tdpt_state_type    state_ff, state_in;
   tdpt_pkg::tdpt_div_stat_type div_stat;

   logic [VALUE_WIDTH-1:0] cand_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic [PW-1:0]          last_ff;
   logic [PW-1:0]          limit_ff;
   logic [PW-1:0]          prime_ff;
   logic [FW-1:0]          sq_ff;
   logic                   res_prime_ff, res_undec_ff;
   logic                   rsp_valid_ff;
   logic [FW-1:0]          rsp_value_ff;
   logic                   rsp_prime_ff, rsp_undec_ff;

   logic [PW-1:0] rd_data;
   logic [FW-1:0] cand_wide;
   logic          accept, rd_en, div_start, idx_inc, res_load;
   logic          res_prime_in, res_undec_in, out_load, append;
   logic          out_free, walk_end, cand_small, cand_tiny;

   assign cand_wide  = FW'(cand_ff);
   assign cand_small = (cand_ff < VALUE_WIDTH'(2));
   assign cand_tiny  = (cand_ff < VALUE_WIDTH'(4));
   assign walk_end   = (idx_ff >= count_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = reset || (state_ff != tdpt_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;

   // Advance the walk: read a prime, square it, bound check, divide
   always_comb begin
      state_in     = state_ff;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      idx_inc      = 1'b0;
      res_load     = 1'b0;
      res_prime_in = 1'b0;
      res_undec_in = 1'b0;
      out_load     = 1'b0;
      append       = 1'b0;
      unique case (state_ff)
         tdpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tdpt_pkg::ST_WALK;
            end
         end
         tdpt_pkg::ST_WALK: begin
            if (cand_small) begin
               res_load = 1'b1;
               state_in = tdpt_pkg::ST_FINISH;
            end else if (walk_end) begin
               res_load     = 1'b1;
               res_prime_in = cand_tiny;
               res_undec_in = !cand_tiny;
               state_in     = tdpt_pkg::ST_FINISH;
            end else begin
               rd_en    = 1'b1;
               state_in = tdpt_pkg::ST_FETCH;
            end
         end
         tdpt_pkg::ST_FETCH: begin
            state_in = tdpt_pkg::ST_CHECK;
         end
         tdpt_pkg::ST_CHECK: begin
            if (sq_ff > cand_wide) begin
               res_load     = 1'b1;
               res_prime_in = 1'b1;
               state_in     = tdpt_pkg::ST_FINISH;
            end else begin
               div_start = 1'b1;
               state_in  = tdpt_pkg::ST_DIVIDE;
            end
         end
         tdpt_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero && prime_ff != '0) begin
                  res_load = 1'b1;
                  state_in = tdpt_pkg::ST_FINISH;
               end else begin
                  idx_inc  = 1'b1;
                  state_in = tdpt_pkg::ST_WALK;
               end
            end
         end
         tdpt_pkg::ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               append   = res_prime_ff && (cand_wide <= FW'(limit_ff))
                          && (count_ff < CNT_W'(TABLE_DEPTH))
                          && (count_ff == '0 || cand_wide > FW'(last_ff));
               state_in = tdpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdpt_pkg::ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Table fill count, limit register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= tdpt_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept && req_first) begin
            count_ff <= '0;
         end else if (append) begin
            count_ff <= count_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: candidate, walk index, squared prime, result and output beat
   always_ff @(posedge clock) begin
      if (accept) begin
         cand_ff <= req_candidate[VALUE_WIDTH-1:0];
         idx_ff  <= '0;
      end else if (idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (state_ff == tdpt_pkg::ST_FETCH) begin
         prime_ff <= rd_data;
         sq_ff    <= FW'(rd_data) * FW'(rd_data);
      end
      if (res_load) begin
         res_prime_ff <= res_prime_in;
         res_undec_ff <= res_undec_in;
      end
      if (append) begin
         last_ff <= cand_wide[PW-1:0];
      end
      if (out_load) begin
         rsp_value_ff <= cand_wide;
         rsp_prime_ff <= res_prime_ff;
         rsp_undec_ff <= res_undec_ff;
      end
   end

   tdpt_ram #(
      .WIDTH (PW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (append),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (cand_wide[PW-1:0]),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   tdpt_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (prime_ff),
      .stat     (div_stat)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tested_value = rsp_value_ff;
   assign rsp_is_prime     = rsp_prime_ff;
   assign rsp_undecided    = rsp_undec_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "table count overflow")
   `ASSERT_IMPLIES(a_result_excl, clock, reset, rsp_valid_ff, !(rsp_prime_ff && rsp_undec_ff), "prime and undecided together")
   `ASSERT_IMPLIES(a_div_in_walk, clock, reset, div_stat.done, state_ff == tdpt_pkg::ST_DIVIDE, "remainder outside divide state")
   `ASSERT_NEXT(a_append_count, clock, reset, append, count_ff == $past(count_ff) + 1'b1, "append lost")

endmodule
